/* rtl/core/pvsa_pkg.sv */
`default_nettype none
package pvsa_pkg;

   localparam int SOUND_ID_BITS = 10;

   localparam logic [3:0] OP_ALLOC       = 4'd0;
   localparam logic [3:0] OP_STOP        = 4'd1;
   localparam logic [3:0] OP_STOP_LOOP   = 4'd2;
   localparam logic [3:0] OP_PAUSE       = 4'd3;
   localparam logic [3:0] OP_RESUME      = 4'd4;
   localparam logic [3:0] OP_PAUSE_ALL   = 4'd5;
   localparam logic [3:0] OP_RESUME_ALL  = 4'd6;
   localparam logic [3:0] OP_STOP_ALL    = 4'd7;
   localparam logic [3:0] OP_QUERY       = 4'd8;
   localparam logic [3:0] OP_FIND        = 4'd9;

   localparam logic [1:0] KIND_FREE   = 2'd0;
   localparam logic [1:0] KIND_NORMAL = 2'd1;
   localparam logic [1:0] KIND_LOOP   = 2'd2;
   localparam logic [1:0] KIND_STREAM = 2'd3;

   localparam logic [1:0] REQ_KIND_NORMAL = 2'd0;
   localparam logic [1:0] REQ_KIND_LOOP   = 2'd1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_SLOT   = 2'd1;
   localparam logic [1:0] ST_BAD_HANDLE = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [3:0]               op;
      logic [1:0]               kind;
      logic [7:0]               priority_req;
      logic [7:0]               volume;
      logic [SOUND_ID_BITS-1:0] sound_id;
      logic [31:0]              handle;
   } pvsa_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] result_handle;
      logic [7:0]  slot;
      logic        evicted;
      logic [31:0] evicted_handle;
      logic        playing;
   } pvsa_rsp_type;

   // transaction record walking down the cell row
   typedef struct packed {
      logic        vld;
      logic [3:0]  op;
      logic [1:0]  kind;
      logic [15:0] wnew;
      logic [15:0] sid;
      logic [31:0] handle;
      logic        free_found;
      logic [7:0]  free_idx;
      logic        low_found;
      logic [7:0]  low_idx;
      logic [15:0] low_w;
      logic [31:0] low_h;
      logic        eq_found;
      logic [7:0]  eq_idx;
      logic [31:0] eq_h;
      logic        hit;
      logic [7:0]  hit_idx;
      logic [31:0] hit_h;
   } pvsa_pass_type;

   typedef struct packed {
      logic        vld;
      logic [7:0]  idx;
      logic [1:0]  kind;
      logic [31:0] handle;
      logic [15:0] weight;
      logic [15:0] sid;
   } pvsa_commit_type;

endpackage
`default_nettype wire

/* rtl/core/pvsa_cell.sv */
`default_nettype none
module pvsa_cell
   import pvsa_pkg::*;
#(
   parameter int I = 0
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire pvsa_pass_type   rec_in,
   input  wire pvsa_commit_type cmt,
   output pvsa_pass_type        rec_out
);

   localparam logic [7:0] IDX = 8'(I);

   logic [1:0]               kind_ff, kind_in;
   logic                     paused_ff, paused_in;
   logic [31:0]              handle_ff;
   logic [15:0]              weight_ff;
   logic [SOUND_ID_BITS-1:0] sound_ff;
   pvsa_pass_type            rec_ff, rec_in_nx;
   logic                     mine;

   assign mine = (rec_in.handle[7:0] == IDX) && (rec_in.handle == handle_ff) &&
                 (kind_ff != KIND_FREE);

   always_comb begin
      rec_in_nx = rec_in;
      kind_in   = kind_ff;
      paused_in = paused_ff;
      if (rec_in.vld) begin
         case (rec_in.op)
            OP_ALLOC: begin
               if (kind_ff == KIND_FREE && !rec_in.free_found) begin
                  rec_in_nx.free_found = 1'b1;
                  rec_in_nx.free_idx   = IDX;
               end
               if (kind_ff == KIND_NORMAL) begin
                  if (weight_ff < rec_in.wnew) begin
                     if (!rec_in.low_found || rec_in.low_w > weight_ff) begin
                        rec_in_nx.low_found = 1'b1;
                        rec_in_nx.low_idx   = IDX;
                        rec_in_nx.low_w     = weight_ff;
                        rec_in_nx.low_h     = handle_ff;
                     end
                  end else if (!rec_in.eq_found && weight_ff == rec_in.wnew) begin
                     rec_in_nx.eq_found = 1'b1;
                     rec_in_nx.eq_idx   = IDX;
                     rec_in_nx.eq_h     = handle_ff;
                  end
               end
            end
            OP_STOP, OP_STOP_LOOP, OP_PAUSE, OP_RESUME, OP_QUERY: begin
               if (mine) begin
                  rec_in_nx.hit = 1'b1;
                  case (rec_in.op)
                     OP_STOP: begin
                        kind_in   = KIND_FREE;
                        paused_in = 1'b0;
                     end
                     OP_STOP_LOOP: if (kind_ff == KIND_LOOP) kind_in = KIND_NORMAL;
                     OP_PAUSE:     paused_in = 1'b1;
                     OP_RESUME:    paused_in = 1'b0;
                     default: ;
                  endcase
               end
            end
            OP_PAUSE_ALL:  if (kind_ff != KIND_FREE) paused_in = 1'b1;
            OP_RESUME_ALL: if (kind_ff != KIND_FREE) paused_in = 1'b0;
            OP_STOP_ALL: begin
               if (kind_ff != KIND_FREE) begin
                  kind_in   = KIND_FREE;
                  paused_in = 1'b0;
               end
            end
            OP_FIND: begin
               if (!rec_in.hit && kind_ff != KIND_FREE &&
                   sound_ff == rec_in.sid[SOUND_ID_BITS-1:0]) begin
                  rec_in_nx.hit     = 1'b1;
                  rec_in_nx.hit_idx = IDX;
                  rec_in_nx.hit_h   = handle_ff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= KIND_FREE;
         paused_ff  <= 1'b0;
         handle_ff  <= '0;
         rec_ff.vld <= 1'b0;
      end else begin
         rec_ff <= rec_in_nx;
         if (cmt.vld && cmt.idx == IDX) begin
            kind_ff   <= cmt.kind;
            paused_ff <= 1'b0;
            handle_ff <= cmt.handle;
         end else begin
            kind_ff   <= kind_in;
            paused_ff <= paused_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmt.vld && cmt.idx == IDX) begin
         weight_ff <= cmt.weight;
         sound_ff  <= cmt.sid[SOUND_ID_BITS-1:0];
      end
   end

   assign rec_out = rec_ff;

endmodule
`default_nettype wire

/* rtl/core/priority_voice_slot_allocator_unit.sv */
`default_nettype none
// Voice slot allocator: VOICES slots live in a row of cells, and every transaction walks the
// row one cell per clock from the head register to the tail, and its result is registered;
// busy stays high meanwhile, so no start is taken until it is through. The single result shows
// on rsp_payload for one cycle with rsp_strobe and cannot be held off by the receiver.
module priority_voice_slot_allocator_unit
   import pvsa_pkg::*;
#(
   parameter int VOICES = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire pvsa_req_type req_payload,
   output logic              rsp_strobe,
   output pvsa_rsp_type      rsp_payload
);

   localparam logic [15:0] SID_MASK = 16'((32'd1 << SOUND_ID_BITS) - 1);

   pvsa_pass_type   chain [0:VOICES];
   pvsa_pass_type   head_ff, head_in;
   pvsa_pass_type   tail;
   pvsa_commit_type cmt;
   pvsa_rsp_type    rsp_ff, rsp_in;
   logic            busy_ff, strobe_ff;
   logic [23:0]     play_counter_ff, pc_next;
   logic [1:0]      new_kind;
   logic            accept;

   assign accept   = start && !busy_ff;
   assign chain[0] = head_ff;
   assign tail     = chain[VOICES];
   assign pc_next  = play_counter_ff + 24'd1;

   genvar g;
   generate
      for (g = 0; g < VOICES; g++) begin : g_cell
         pvsa_cell #(.I(g)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .rec_in  (chain[g]),
            .cmt     (cmt),
            .rec_out (chain[g+1])
         );
      end
   endgenerate

   always_comb begin
      head_in = '0;
      if (accept) begin
         head_in.vld    = 1'b1;
         head_in.op     = req_payload.op;
         head_in.kind   = req_payload.kind;
         head_in.wnew   = {8'd0, req_payload.priority_req} * {8'd0, req_payload.volume};
         head_in.sid    = 16'(req_payload.sound_id) & SID_MASK;
         head_in.handle = req_payload.handle;
      end
   end

   always_comb begin
      case (tail.kind)
         REQ_KIND_NORMAL: new_kind = KIND_NORMAL;
         REQ_KIND_LOOP:   new_kind = KIND_LOOP;
         default:         new_kind = KIND_STREAM;
      endcase
   end

   always_comb begin
      rsp_in     = '0;
      cmt        = '0;
      cmt.kind   = new_kind;
      cmt.weight = tail.wnew;
      cmt.sid    = tail.sid;
      case (tail.op)
         OP_ALLOC: begin
            if (tail.free_found) cmt.idx = tail.free_idx;
            else if (tail.low_found) cmt.idx = tail.low_idx;
            else cmt.idx = tail.eq_idx;
            if (tail.free_found || tail.low_found || tail.eq_found) begin
               cmt.vld              = tail.vld;
               cmt.handle           = {pc_next, cmt.idx};
               rsp_in.result_handle = cmt.handle;
               rsp_in.slot          = cmt.idx;
               if (!tail.free_found) begin
                  rsp_in.evicted        = 1'b1;
                  rsp_in.evicted_handle = tail.low_found ? tail.low_h : tail.eq_h;
               end
            end else begin
               rsp_in.status = ST_NO_SLOT;
            end
         end
         OP_STOP, OP_STOP_LOOP, OP_PAUSE, OP_RESUME, OP_QUERY: begin
            rsp_in.slot = tail.handle[7:0];
            if (tail.hit) begin
               rsp_in.result_handle = tail.handle;
               rsp_in.playing       = (tail.op == OP_QUERY);
            end else begin
               rsp_in.status = ST_BAD_HANDLE;
            end
         end
         OP_FIND: begin
            if (tail.hit) begin
               rsp_in.result_handle = tail.hit_h;
               rsp_in.slot          = tail.hit_idx;
               rsp_in.playing       = 1'b1;
            end else begin
               rsp_in.status = ST_NOT_FOUND;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         strobe_ff       <= 1'b0;
         play_counter_ff <= '0;
         head_ff.vld     <= 1'b0;
      end else begin
         strobe_ff <= tail.vld;
         if (tail.vld) busy_ff <= 1'b0;
         else if (accept) busy_ff <= 1'b1;
         if (cmt.vld) play_counter_ff <= pc_next;
         head_ff <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tail.vld) rsp_ff <= rsp_in;
   end

   assign busy        = busy_ff;
   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

/* rtl/core/pvsa_checker.sv */
`default_nettype none
module pvsa_checker
   import pvsa_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         start,
   input wire logic         busy,
   input wire logic         rsp_strobe,
   input wire pvsa_rsp_type rsp_payload
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after transaction");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("result while busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("back-to-back results");

   a_evict_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.evicted |-> rsp_payload.status == ST_OK)
      else $error("eviction with failing status");

endmodule

bind priority_voice_slot_allocator_unit pvsa_checker u_pvsa_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);
`default_nettype wire

/* test/priority_voice_slot_allocator_unit_tb.sv */
`default_nettype none
module priority_voice_slot_allocator_unit_tb
   import pvsa_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_VOICES = 256;
   localparam int RANDOM_ITEMS = 1030;
   localparam int STALL_LIMIT = 5000;

   typedef struct {
      pvsa_req_type req;
      bit           fixed;
      pvsa_rsp_type rsp;
   } directed_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   pvsa_req_type req_payload = '0;
   logic         rsp_strobe;
   pvsa_rsp_type rsp_payload;

   logic [1:0]  voice_kind   [NUM_VOICES];
   logic        voice_paused [NUM_VOICES];
   logic [31:0] voice_handle [NUM_VOICES];
   logic [7:0]  voice_prio   [NUM_VOICES];
   logic [7:0]  voice_vol    [NUM_VOICES];
   logic [9:0]  voice_sound  [NUM_VOICES];
   logic [23:0] play_count;

   pvsa_rsp_type     pending_rsp [$];
   directed_row_type directed_rows [$];
   int               error_count = 0;
   int               stall_cycles = 0;
   int               idle_pct = 7;

   priority_voice_slot_allocator_unit uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   always #2 clock = ~clock;

   function automatic pvsa_req_type make_req(logic [3:0] op, logic [1:0] kind, logic [7:0] prio,
                                             logic [7:0] vol, logic [9:0] sid, logic [31:0] h);
      pvsa_req_type r;
      r.op = op;
      r.kind = kind;
      r.priority_req = prio;
      r.volume = vol;
      r.sound_id = sid;
      r.handle = h;
      return r;
   endfunction

   function automatic pvsa_rsp_type make_rsp(logic [1:0] st, logic [31:0] rh, logic [7:0] sl,
                                             logic ev, logic [31:0] evh, logic pl);
      pvsa_rsp_type r;
      r.status = st;
      r.result_handle = rh;
      r.slot = sl;
      r.evicted = ev;
      r.evicted_handle = evh;
      r.playing = pl;
      return r;
   endfunction

   function automatic pvsa_rsp_type predict_voice_op(pvsa_req_type r);
      pvsa_rsp_type o;
      int pick, equal, s;
      logic [15:0] wnew, w;
      o = '0;
      pick = -1;
      equal = -1;
      wnew = {8'd0, r.priority_req} * {8'd0, r.volume};
      case (r.op)
         OP_ALLOC: begin
            for (int i = 0; i < NUM_VOICES; i++)
               if (pick < 0 && voice_kind[i] == KIND_FREE) pick = i;
            if (pick < 0) begin
               for (int i = 0; i < NUM_VOICES; i++) begin
                  if (voice_kind[i] == KIND_NORMAL) begin
                     w = {8'd0, voice_prio[i]} * {8'd0, voice_vol[i]};
                     if (w < wnew) begin
                        if (pick < 0 || {8'd0, voice_prio[pick]} * {8'd0, voice_vol[pick]} > w)
                           pick = i;
                     end else if (equal < 0 && w == wnew) begin
                        equal = i;
                     end
                  end
               end
               if (pick < 0) pick = equal;
               if (pick >= 0) begin
                  o.evicted = 1'b1;
                  o.evicted_handle = voice_handle[pick];
               end
            end
            if (pick < 0) begin
               o.status = ST_NO_SLOT;
            end else begin
               play_count = play_count + 1'b1;
               voice_handle[pick] = {play_count, 8'(pick)};
               voice_kind[pick] = r.kind == REQ_KIND_NORMAL ? KIND_NORMAL :
                                  r.kind == REQ_KIND_LOOP ? KIND_LOOP : KIND_STREAM;
               voice_paused[pick] = 1'b0;
               voice_prio[pick] = r.priority_req;
               voice_vol[pick] = r.volume;
               voice_sound[pick] = r.sound_id;
               o.result_handle = voice_handle[pick];
               o.slot = 8'(pick);
            end
         end
         OP_STOP, OP_STOP_LOOP, OP_PAUSE, OP_RESUME, OP_QUERY: begin
            s = int'(r.handle[7:0]);
            o.slot = r.handle[7:0];
            if (voice_handle[s] != r.handle || voice_kind[s] == KIND_FREE) begin
               o.status = ST_BAD_HANDLE;
            end else begin
               o.result_handle = r.handle;
               case (r.op)
                  OP_STOP: begin
                     voice_kind[s] = KIND_FREE;
                     voice_paused[s] = 1'b0;
                  end
                  OP_STOP_LOOP: if (voice_kind[s] == KIND_LOOP) voice_kind[s] = KIND_NORMAL;
                  OP_PAUSE: voice_paused[s] = 1'b1;
                  OP_RESUME: voice_paused[s] = 1'b0;
                  default: o.playing = 1'b1;
               endcase
            end
         end
         OP_PAUSE_ALL, OP_RESUME_ALL, OP_STOP_ALL: begin
            for (int i = 0; i < NUM_VOICES; i++) begin
               if (voice_kind[i] != KIND_FREE) begin
                  if (r.op == OP_PAUSE_ALL) begin
                     voice_paused[i] = 1'b1;
                  end else if (r.op == OP_RESUME_ALL) begin
                     voice_paused[i] = 1'b0;
                  end else begin
                     voice_kind[i] = KIND_FREE;
                     voice_paused[i] = 1'b0;
                  end
               end
            end
         end
         OP_FIND: begin
            o.status = ST_NOT_FOUND;
            for (int i = 0; i < NUM_VOICES; i++) begin
               if (o.status == ST_NOT_FOUND && voice_kind[i] != KIND_FREE &&
                   voice_sound[i] == r.sound_id) begin
                  o.status = ST_OK;
                  o.result_handle = voice_handle[i];
                  o.slot = 8'(i);
                  o.playing = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic logic [7:0] pick_level();
      logic [7:0] v;
      case ($urandom_range(0, 3))
         0: v = 8'd0;
         1: v = 8'd255;
         2: v = 8'($urandom_range(1, 4));
         default: v = 8'($urandom);
      endcase
      return v;
   endfunction

   function automatic pvsa_req_type random_req();
      pvsa_req_type r;
      int roll, s;
      r = '0;
      r.kind = $urandom_range(0, 9) < 8 ? REQ_KIND_NORMAL : 2'($urandom_range(1, 3));
      r.priority_req = pick_level();
      r.volume = pick_level();
      r.sound_id = $urandom_range(0, 1) ? 10'($urandom_range(0, 15)) : 10'($urandom);
      s = $urandom_range(0, NUM_VOICES - 1);
      for (int i = 0; i < NUM_VOICES; i++)
         if (voice_kind[s] == KIND_FREE) s = (s + 1) % NUM_VOICES;
      r.handle = voice_handle[s];
      roll = $urandom_range(0, 999);
      if (roll < 580) r.op = OP_ALLOC;
      else if (roll < 630) r.op = OP_STOP;
      else if (roll < 680) r.op = OP_STOP_LOOP;
      else if (roll < 730) r.op = OP_PAUSE;
      else if (roll < 780) r.op = OP_RESUME;
      else if (roll < 850) r.op = OP_QUERY;
      else if (roll < 920) r.op = OP_FIND;
      else if (roll < 940) r.op = OP_PAUSE_ALL;
      else if (roll < 960) r.op = OP_RESUME_ALL;
      else if (roll < 963) r.op = OP_STOP_ALL;
      else if (roll < 980) r.op = 4'($urandom_range(10, 15));
      else r.op = 4'($urandom_range(OP_STOP, OP_RESUME));
      if (roll >= 963 && roll < 990) begin
         r.handle = $urandom;
         if ($urandom_range(0, 1)) r.handle[31:8] = voice_handle[r.handle[7:0]][31:8] + 1'b1;
      end
      return r;
   endfunction

   task automatic send_item(pvsa_req_type r, bit fixed, pvsa_rsp_type rsp);
      pvsa_rsp_type predicted;
      req_payload <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predicted = predict_voice_op(r);
      pending_rsp.push_back(fixed ? rsp : predicted);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
   endtask

   task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
         $error("%s: expected %h, actual %h", name, exp, act);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $error("result without a pending transaction");
            error_count++;
         end else begin
            pvsa_rsp_type e;
            e = pending_rsp.pop_front();
            check_field("status", 32'(e.status), 32'(rsp_payload.status));
            check_field("result_handle", e.result_handle, rsp_payload.result_handle);
            check_field("slot", 32'(e.slot), 32'(rsp_payload.slot));
            check_field("evicted", 32'(e.evicted), 32'(rsp_payload.evicted));
            check_field("evicted_handle", e.evicted_handle, rsp_payload.evicted_handle);
            check_field("playing", 32'(e.playing), 32'(rsp_payload.playing));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic add_row(pvsa_req_type r, bit fixed, pvsa_rsp_type rsp);
      directed_row_type row;
      row.req = r;
      row.fixed = fixed;
      row.rsp = rsp;
      directed_rows.push_back(row);
   endtask

   initial begin
      for (int i = 0; i < NUM_VOICES; i++) begin
         voice_kind[i] = KIND_FREE;
         voice_paused[i] = 1'b0;
         voice_handle[i] = '0;
         voice_prio[i] = '0;
         voice_vol[i] = '0;
         voice_sound[i] = '0;
      end
      play_count = '0;

      add_row(make_req(OP_QUERY, 0, 0, 0, 0, 32'h0), 1, make_rsp(ST_BAD_HANDLE, 0, 0, 0, 0, 0));
      add_row(make_req(OP_ALLOC, REQ_KIND_NORMAL, 255, 255, 10'd1023, 32'hFFFF_FFFF), 1,
              make_rsp(ST_OK, 32'h100, 0, 0, 0, 0));
      add_row(make_req(OP_ALLOC, 2'd3, 0, 0, 0, 0), 1, make_rsp(ST_OK, 32'h201, 1, 0, 0, 0));
      add_row(make_req(OP_FIND, 0, 0, 0, 10'd1023, 0), 1, make_rsp(ST_OK, 32'h100, 0, 0, 0, 1));
      add_row(make_req(OP_FIND, 0, 0, 0, 10'd5, 0), 1, make_rsp(ST_NOT_FOUND, 0, 0, 0, 0, 0));
      add_row(make_req(OP_QUERY, 0, 0, 0, 0, 32'h100), 1, make_rsp(ST_OK, 32'h100, 0, 0, 0, 1));
      add_row(make_req(OP_PAUSE, 0, 0, 0, 0, 32'h100), 1, make_rsp(ST_OK, 32'h100, 0, 0, 0, 0));
      add_row(make_req(OP_PAUSE, 0, 0, 0, 0, 32'h100), 1, make_rsp(ST_OK, 32'h100, 0, 0, 0, 0));
      add_row(make_req(OP_RESUME, 0, 0, 0, 0, 32'h100), 1, make_rsp(ST_OK, 32'h100, 0, 0, 0, 0));
      add_row(make_req(OP_RESUME, 0, 0, 0, 0, 32'h100), 1, make_rsp(ST_OK, 32'h100, 0, 0, 0, 0));
      add_row(make_req(OP_STOP_LOOP, 0, 0, 0, 0, 32'h201), 1,
              make_rsp(ST_OK, 32'h201, 1, 0, 0, 0));
      add_row(make_req(OP_ALLOC, REQ_KIND_LOOP, 8'h80, 8'h7F, 10'h2AA, 0), 1,
              make_rsp(ST_OK, 32'h302, 2, 0, 0, 0));
      add_row(make_req(OP_STOP_LOOP, 0, 0, 0, 0, 32'h302), 0, '0);
      add_row(make_req(OP_STOP, 0, 0, 0, 0, 32'h100), 1, make_rsp(ST_OK, 32'h100, 0, 0, 0, 0));
      add_row(make_req(OP_STOP, 0, 0, 0, 0, 32'h100), 1,
              make_rsp(ST_BAD_HANDLE, 0, 0, 0, 0, 0));
      add_row(make_req(OP_QUERY, 0, 0, 0, 0, 32'hFFFF_FFFF), 1,
              make_rsp(ST_BAD_HANDLE, 0, 8'hFF, 0, 0, 0));
      add_row(make_req(OP_PAUSE, 0, 0, 0, 0, 32'h401), 1,
              make_rsp(ST_BAD_HANDLE, 0, 1, 0, 0, 0));
      add_row(make_req(4'd10, 0, 0, 0, 0, 32'h201), 1, '0);
      add_row(make_req(4'd15, 2'd3, 8'hFF, 8'hFF, 10'h3FF, 32'hFFFF_FFFF), 1, '0);
      add_row(make_req(OP_PAUSE_ALL, 0, 0, 0, 0, 0), 1, '0);
      add_row(make_req(OP_RESUME_ALL, 0, 0, 0, 0, 0), 1, '0);
      add_row(make_req(OP_FIND, 0, 0, 0, 10'h2AA, 0), 0, '0);
      add_row(make_req(OP_STOP_ALL, 0, 0, 0, 0, 0), 1, '0);
      add_row(make_req(OP_QUERY, 0, 0, 0, 0, 32'h201), 1,
              make_rsp(ST_BAD_HANDLE, 0, 1, 0, 0, 0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].rsp);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) begin
            start <= 1'b0;
            while (pending_rsp.size() != 0) @(posedge clock);
            idle_pct = n == RANDOM_ITEMS / 3 ? 67 : 0;
         end
         send_item(random_req(), 0, '0);
      end
      start <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (pending_rsp.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
